@@ sv/mcpc_pkg.sv @@
// Shared types and constants for the masked channel percentile color unit.
// Holds the pixel and result transaction structs; no dependencies.
package mcpc_pkg;

	localparam int unsigned MaxPixels = 65536;
	localparam int unsigned CountW    = $clog2(MaxPixels + 1);
	localparam int unsigned Bins      = 256;
	localparam int unsigned BinW      = $clog2(Bins);
	localparam int unsigned HistW     = CountW;
	localparam int unsigned Chans     = 3;
	localparam int unsigned MinW      = 16;
	localparam logic [MinW-1:0] MinPixelsReset = MinW'(4);

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       in_mask;
		logic       last;
	} pixel_t;

	typedef struct packed {
		logic [7:0]        red_p75;
		logic [7:0]        green_p75;
		logic [7:0]        blue_p75;
		logic              too_few;
		logic [CountW-1:0] pixel_count;
	} result_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DRAIN = 5'b00010,
		ST_WALK  = 5'b00100,
		ST_FLUSH = 5'b01000,
		ST_CLEAR = 5'b10000
	} state_t;

endpackage

@@ sv/masked_channel_percentile_color_unit.sv @@
// Top level of the masked channel percentile color unit.
// Uses mcpc_pkg for the transaction structs, sizes and state encoding.

// Pixels are taken one per clock while busy is low; a masked pixel adds one to
// the bin of each channel in three 256-entry histogram RAMs by a read-modify-write
// with forwarding, so back-to-back hits on the same bin are safe. After the pixel
// marked last, busy stays high: a drain state lets the final increment land, then
// one RAM port per channel walks all 256 bins, summing counts, finding the 75th
// percentile and writing each bin back to zero. The result follows as a one-cycle
// done strobe; it cannot be held off, so capture it on that cycle. Right after
// reset, busy stays high while a clearing pass zeroes every bin. The min_pixels
// register may be written at any time the unit is idle.
module masked_channel_percentile_color_unit
	import mcpc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  pixel_t          pixel,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [MinW-1:0] cfg_data,
	output logic            done,
	output result_t         result
);

	state_t state_q;

	logic [MinW-1:0]   min_pixels_q;
	logic [CountW-1:0] count_q;
	logic [CountW-1:0] target_q;
	logic              few_q;

	logic              accept;
	logic              counted;

	// Pixel increment stage and write forwarding.
	logic              pix_vld_s1;
	logic [BinW-1:0]   pix_addr_s1 [Chans];
	logic              fwd_vld_q;
	logic [BinW-1:0]   fwd_addr_q  [Chans];
	logic [HistW-1:0]  fwd_data_q  [Chans];

	// Bin walk.
	logic [BinW-1:0]   walk_addr_q;
	logic              walk_vld_s1;
	logic [BinW-1:0]   walk_addr_s1;
	logic [HistW-1:0]  acc_q       [Chans];
	logic              found_q     [Chans];
	logic [7:0]        pct_q       [Chans];

	// RAM ports.
	logic [BinW-1:0]   rd_addr     [Chans];
	logic [HistW-1:0]  rd_data     [Chans];
	logic              wr_en;
	logic [BinW-1:0]   wr_addr     [Chans];
	logic [HistW-1:0]  wr_data     [Chans];
	logic [HistW-1:0]  inc_data    [Chans];
	logic [HistW-1:0]  acc_next    [Chans];
	logic              hit         [Chans];
	logic [7:0]        pct_final   [Chans];
	logic              walk_end;
	logic [CountW+1:0] count_x3;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign counted   = accept && pixel.in_mask && (count_q < CountW'(MaxPixels));
	assign walk_end  = walk_vld_s1 && (walk_addr_s1 == BinW'(Bins - 1));
	assign count_x3  = {1'b0, count_q, 1'b0} + {2'b00, count_q};

	always_comb begin
		wr_en = pix_vld_s1 || walk_vld_s1 || (state_q == ST_CLEAR);
		for (int c = 0; c < Chans; c++) begin
			if (state_q == ST_WALK) begin
				rd_addr[c] = walk_addr_q;
			end else begin
				case (c)
					0:       rd_addr[c] = pixel.red;
					1:       rd_addr[c] = pixel.green;
					default: rd_addr[c] = pixel.blue;
				endcase
			end
			if (fwd_vld_q && (fwd_addr_q[c] == pix_addr_s1[c])) begin
				inc_data[c] = fwd_data_q[c] + HistW'(1);
			end else begin
				inc_data[c] = rd_data[c] + HistW'(1);
			end
			if (walk_vld_s1) begin
				wr_addr[c] = walk_addr_s1;
				wr_data[c] = '0;
			end else if (state_q == ST_CLEAR) begin
				wr_addr[c] = walk_addr_q;
				wr_data[c] = '0;
			end else begin
				wr_addr[c] = pix_addr_s1[c];
				wr_data[c] = inc_data[c];
			end
			acc_next[c] = acc_q[c] + rd_data[c];
			hit[c]      = !found_q[c] && (acc_next[c] > target_q);
			if (found_q[c]) begin
				pct_final[c] = pct_q[c];
			end else if (hit[c]) begin
				pct_final[c] = walk_addr_s1;
			end else begin
				pct_final[c] = '0;
			end
		end
	end

	for (genvar g = 0; g < Chans; g++) begin : g_hist
		logic [HistW-1:0] mem [Bins];

		always_ff @(posedge clk) begin
			if (wr_en) begin
				mem[wr_addr[g]] <= wr_data[g];
			end
			rd_data[g] <= mem[rd_addr[g]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			min_pixels_q <= MinPixelsReset;
			count_q      <= '0;
			pix_vld_s1   <= 1'b0;
			fwd_vld_q    <= 1'b0;
			walk_vld_s1  <= 1'b0;
			walk_addr_q  <= '0;
			done         <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				min_pixels_q <= cfg_data;
			end
			pix_vld_s1  <= counted;
			fwd_vld_q   <= pix_vld_s1;
			walk_vld_s1 <= (state_q == ST_WALK);
			done        <= walk_end;
			if (counted) begin
				count_q <= count_q + CountW'(1);
			end
			case (state_q)
				ST_CLEAR: begin
					walk_addr_q <= walk_addr_q + BinW'(1);
					if (walk_addr_q == BinW'(Bins - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && pixel.last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					walk_addr_q <= '0;
					state_q     <= ST_WALK;
				end
				ST_WALK: begin
					walk_addr_q <= walk_addr_q + BinW'(1);
					if (walk_addr_q == BinW'(Bins - 1)) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (walk_end) begin
						state_q <= ST_IDLE;
						count_q <= '0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload and datapath registers.
	always_ff @(posedge clk) begin
		for (int c = 0; c < Chans; c++) begin
			fwd_addr_q[c] <= pix_addr_s1[c];
			fwd_data_q[c] <= inc_data[c];
		end
		pix_addr_s1[0] <= pixel.red;
		pix_addr_s1[1] <= pixel.green;
		pix_addr_s1[2] <= pixel.blue;
		walk_addr_s1   <= walk_addr_q;
		if (state_q == ST_DRAIN) begin
			target_q <= count_x3[CountW+1:2];
			few_q    <= ({1'b0, count_q} < {{(CountW + 1 - MinW){1'b0}}, min_pixels_q});
			for (int c = 0; c < Chans; c++) begin
				acc_q[c]   <= '0;
				found_q[c] <= 1'b0;
				pct_q[c]   <= '0;
			end
		end else if (walk_vld_s1) begin
			for (int c = 0; c < Chans; c++) begin
				acc_q[c] <= acc_next[c];
				if (hit[c]) begin
					found_q[c] <= 1'b1;
					pct_q[c]   <= walk_addr_s1;
				end
			end
		end
		if (walk_end) begin
			result.red_p75     <= few_q ? 8'd0 : pct_final[0];
			result.green_p75   <= few_q ? 8'd0 : pct_final[1];
			result.blue_p75    <= few_q ? 8'd0 : pct_final[2];
			result.too_few     <= few_q;
			result.pixel_count <= count_q;
		end
	end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for masked_channel_percentile_color_unit: directed and random pixel strips,
// checked against a per-channel 75th percentile histogram predictor. Depends on mcpc_pkg.
module tb_top
	import mcpc_pkg::*;
();

	typedef enum int unsigned {
		COLORS_UNIFORM,
		COLORS_CLUSTER,
		COLORS_EXTREME
	} color_mode_t;

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            start     = 1'b0;
	logic            busy;
	pixel_t          pixel     = '0;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic [MinW-1:0] cfg_data  = '0;
	logic            done;
	result_t         result;

	masked_channel_percentile_color_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.pixel     (pixel),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor state: one strip's histograms, its masked count and the threshold register.
	int unsigned     red_bins[Bins];
	int unsigned     green_bins[Bins];
	int unsigned     blue_bins[Bins];
	int unsigned     strip_count;
	logic [MinW-1:0] min_pixels_model = MinPixelsReset;
	result_t         expected_colors[$];

	int unsigned pixels_sent;
	int unsigned strips_sent;
	int unsigned results_checked;
	int unsigned cfg_writes;
	int unsigned mismatches;

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic logic [7:0] p75_bin(input int unsigned hist[Bins], input int unsigned target);
		longint unsigned acc;
		acc = 0;
		for (int v = 0; v < Bins; v++) begin
			acc += hist[v];
			if (acc > target)
				return 8'(v);
		end
		return 8'd0;
	endfunction

	task automatic absorb_pixel(pixel_t p);
		result_t     want;
		int unsigned target;
		if (p.in_mask && strip_count < MaxPixels) begin
			red_bins[p.red]++;
			green_bins[p.green]++;
			blue_bins[p.blue]++;
			strip_count++;
		end
		if (p.last) begin
			want = '0;
			want.too_few = (strip_count < min_pixels_model);
			want.pixel_count = CountW'(strip_count);
			target = (strip_count * 3) / 4;
			if (!want.too_few) begin
				want.red_p75 = p75_bin(red_bins, target);
				want.green_p75 = p75_bin(green_bins, target);
				want.blue_p75 = p75_bin(blue_bins, target);
			end
			expected_colors = {expected_colors, want};
			foreach (red_bins[i]) begin
				red_bins[i] = 0;
				green_bins[i] = 0;
				blue_bins[i] = 0;
			end
			strip_count = 0;
			strips_sent++;
		end
	endtask

	// Leaves start high so that a following call can present its pixel without a gap.
	task automatic send_pixel(pixel_t p);
		start <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (busy);
		pixels_sent++;
		absorb_pixel(p);
	endtask

	task automatic pause_sender(int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain_unit();
		start <= 1'b0;
		while (expected_colors.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_min_pixels(logic [MinW-1:0] value);
		drain_unit();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		min_pixels_model = value;
		cfg_writes++;
	endtask

	function automatic pixel_t mk(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic m, logic l);
		pixel_t p;
		p.red = r;
		p.green = g;
		p.blue = b;
		p.in_mask = m;
		p.last = l;
		return p;
	endfunction

	function automatic logic [7:0] pick_channel(color_mode_t mode, logic [7:0] base);
		case (mode)
			COLORS_CLUSTER: return base + 8'($urandom_range(3));
			COLORS_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
			default:        return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_strip(int unsigned len, int unsigned mask_pct, color_mode_t mode,
			bit allow_idle);
		pixel_t     p;
		logic [7:0] base_r, base_g, base_b;
		base_r = 8'($urandom_range(255));
		base_g = 8'($urandom_range(255));
		base_b = 8'($urandom_range(255));
		for (int i = 0; i < len; i++) begin
			p.red = pick_channel(mode, base_r);
			p.green = pick_channel(mode, base_g);
			p.blue = pick_channel(mode, base_b);
			p.in_mask = ($urandom_range(99) < mask_pct);
			p.last = (i == len - 1);
			if (allow_idle && $urandom_range(4) == 0)
				pause_sender($urandom_range(1, 13));
			send_pixel(p);
		end
	endtask

	// Reset value of the threshold is four: three masked pixels fall short, four do not.
	task automatic test_reset_threshold();
		send_pixel(mk(8'd10, 8'd20, 8'd30, 1'b1, 1'b0));
		send_pixel(mk(8'd11, 8'd21, 8'd31, 1'b1, 1'b0));
		send_pixel(mk(8'd12, 8'd22, 8'd32, 1'b1, 1'b1));
		send_pixel(mk(8'd200, 8'd5, 8'd90, 1'b1, 1'b0));
		send_pixel(mk(8'd100, 8'd6, 8'd91, 1'b1, 1'b0));
		send_pixel(mk(8'd150, 8'd7, 8'd92, 1'b0, 1'b0));
		send_pixel(mk(8'd50, 8'd8, 8'd93, 1'b1, 1'b0));
		send_pixel(mk(8'd0, 8'd9, 8'd94, 1'b1, 1'b1));
		drain_unit();
	endtask

	task automatic test_channel_extremes();
		send_pixel(mk(8'hFF, 8'h00, 8'hFF, 1'b1, 1'b0));
		send_pixel(mk(8'h00, 8'hFF, 8'h00, 1'b1, 1'b0));
		send_pixel(mk(8'hFF, 8'hFF, 8'h00, 1'b1, 1'b0));
		send_pixel(mk(8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1));
		drain_unit();
	endtask

	// Back-to-back hits on one bin exercise the read-modify-write forwarding.
	task automatic test_same_bin_burst();
		repeat (5) send_pixel(mk(8'd17, 8'd17, 8'd17, 1'b1, 1'b0));
		send_pixel(mk(8'd18, 8'd16, 8'd17, 1'b1, 1'b0));
		send_pixel(mk(8'd17, 8'd17, 8'd17, 1'b0, 1'b1));
		drain_unit();
	endtask

	task automatic test_empty_strip();
		set_min_pixels('0);
		send_pixel(mk(8'd77, 8'd88, 8'd99, 1'b0, 1'b1));
		send_pixel(mk(8'd1, 8'd2, 8'd3, 1'b1, 1'b1));
		drain_unit();
	endtask

	task automatic test_max_threshold();
		set_min_pixels('1);
		send_pixel(mk(8'd40, 8'd41, 8'd42, 1'b1, 1'b0));
		send_pixel(mk(8'd43, 8'd44, 8'd45, 1'b1, 1'b1));
		drain_unit();
	endtask

	task automatic test_random_strips(int unsigned n_items, bit allow_idle);
		int unsigned goal;
		int unsigned len;
		int unsigned pct;
		goal = pixels_sent + n_items;
		while (pixels_sent < goal) begin
			len = ($urandom_range(7) == 0) ? $urandom_range(13, 120) : $urandom_range(1, 12);
			case ($urandom_range(9))
				0:       pct = 0;
				1, 2:    pct = 50;
				3, 4, 5: pct = 90;
				default: pct = 100;
			endcase
			send_strip(len, pct, color_mode_t'($urandom_range(2)),
					allow_idle && $urandom_range(2) != 0);
		end
		drain_unit();
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (expected_colors.size() == 0) begin
				report_mismatch("unexpected result, pixel_count", result.pixel_count, 0);
			end else begin
				want = expected_colors.pop_front();
				results_checked++;
				if (result.red_p75 !== want.red_p75)
					report_mismatch("red_p75", result.red_p75, want.red_p75);
				if (result.green_p75 !== want.green_p75)
					report_mismatch("green_p75", result.green_p75, want.green_p75);
				if (result.blue_p75 !== want.blue_p75)
					report_mismatch("blue_p75", result.blue_p75, want.blue_p75);
				if (result.too_few !== want.too_few)
					report_mismatch("too_few", result.too_few, want.too_few);
				if (result.pixel_count !== want.pixel_count)
					report_mismatch("pixel_count", result.pixel_count, want.pixel_count);
			end
		end
	end

	initial begin
		#5000000;
		$display("Timed out with %0d results outstanding.", expected_colors.size());
		$display("tb_top failed");
		$finish;
	end

	initial begin
		foreach (red_bins[i]) begin
			red_bins[i] = 0;
			green_bins[i] = 0;
			blue_bins[i] = 0;
		end
		strip_count = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_threshold();
		test_channel_extremes();
		test_same_bin_burst();
		test_empty_strip();
		test_max_threshold();

		set_min_pixels('0);
		test_random_strips(280, 1'b1);
		set_min_pixels('1);
		test_random_strips(200, 1'b1);
		set_min_pixels(MinW'($urandom_range(1, 30)));
		test_random_strips(300, 1'b1);
		set_min_pixels(MinPixelsReset);
		test_random_strips(300, 1'b1);
		set_min_pixels(MinW'($urandom_range(65535)));
		test_random_strips(120, 1'b1);
		set_min_pixels(MinW'($urandom_range(1, 16)));
		test_random_strips(200, 1'b0);

		repeat (300) @(posedge clk);
		if (expected_colors.size() != 0)
			report_mismatch("results never delivered", expected_colors.size(), 0);
		$display("Ran %0d pixels in %0d strips with %0d threshold writes.",
				pixels_sent, strips_sent, cfg_writes);
		$display("Compared %0d results, %0d mismatches.", results_checked, mismatches);
		if (mismatches == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
